FILE: sv/adpcm_pkg.sv
// package for the nibble predictive adpcm decoder: widths, codes and the step table
`timescale 1ns / 1ps
`default_nettype none

package adpcm_pkg;

    localparam int unsigned HDR_W      = 8;
    localparam int unsigned DAT_W      = 8;
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned VOLUME_W   = 7;
    localparam int unsigned SCALED_W   = 15;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 24;

    localparam logic [POS_W-1:0] BLOCK_LAST = POS_W'(47);
    localparam logic [POS_W-1:0] HALF_START = POS_W'(24);

    typedef enum logic [1:0] {
        PRED_STEP      = 2'd0,
        PRED_PREV      = 2'd1,
        PRED_SLOPE     = 2'd2,
        PRED_HALF_OLD  = 2'd3
    } pred_mode_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // step table, row major: row from the header, column from the code
    localparam sample_t STEP_ROM [0:255] = '{
        8'sd0, 8'sd14, 8'sd28, 8'sd42, 8'sd56, 8'sd70, 8'sd84, 8'sd97,
        -8'sd111, -8'sd97, -8'sd84, -8'sd70, -8'sd56, -8'sd42, -8'sd28, -8'sd14,
        8'sd0, 8'sd13, 8'sd26, 8'sd39, 8'sd52, 8'sd65, 8'sd78, 8'sd91,
        -8'sd104, -8'sd91, -8'sd78, -8'sd65, -8'sd52, -8'sd39, -8'sd26, -8'sd13,
        8'sd0, 8'sd11, 8'sd21, 8'sd32, 8'sd43, 8'sd54, 8'sd64, 8'sd75,
        -8'sd86, -8'sd75, -8'sd64, -8'sd54, -8'sd43, -8'sd32, -8'sd21, -8'sd11,
        8'sd0, 8'sd9, 8'sd18, 8'sd27, 8'sd35, 8'sd44, 8'sd53, 8'sd62,
        -8'sd71, -8'sd62, -8'sd53, -8'sd44, -8'sd35, -8'sd27, -8'sd18, -8'sd9,
        8'sd0, 8'sd7, 8'sd13, 8'sd20, 8'sd27, 8'sd34, 8'sd40, 8'sd47,
        -8'sd54, -8'sd47, -8'sd40, -8'sd34, -8'sd27, -8'sd20, -8'sd13, -8'sd7,
        8'sd0, 8'sd6, 8'sd11, 8'sd17, 8'sd22, 8'sd28, 8'sd33, 8'sd39,
        -8'sd44, -8'sd39, -8'sd33, -8'sd28, -8'sd22, -8'sd17, -8'sd11, -8'sd6,
        8'sd0, 8'sd5, 8'sd9, 8'sd14, 8'sd18, 8'sd23, 8'sd27, 8'sd32,
        -8'sd36, -8'sd32, -8'sd27, -8'sd23, -8'sd18, -8'sd14, -8'sd9, -8'sd5,
        8'sd0, 8'sd4, 8'sd8, 8'sd11, 8'sd15, 8'sd19, 8'sd23, 8'sd26,
        -8'sd30, -8'sd26, -8'sd23, -8'sd19, -8'sd15, -8'sd11, -8'sd8, -8'sd4,
        8'sd0, 8'sd3, 8'sd6, 8'sd9, 8'sd12, 8'sd15, 8'sd17, 8'sd20,
        -8'sd23, -8'sd20, -8'sd17, -8'sd15, -8'sd12, -8'sd9, -8'sd6, -8'sd3,
        8'sd0, 8'sd2, 8'sd5, 8'sd7, 8'sd10, 8'sd12, 8'sd14, 8'sd17,
        -8'sd19, -8'sd17, -8'sd14, -8'sd12, -8'sd10, -8'sd7, -8'sd5, -8'sd2,
        8'sd0, 8'sd2, 8'sd4, 8'sd6, 8'sd8, 8'sd10, 8'sd12, 8'sd14,
        -8'sd16, -8'sd14, -8'sd12, -8'sd10, -8'sd8, -8'sd6, -8'sd4, -8'sd2,
        8'sd0, 8'sd2, 8'sd3, 8'sd5, 8'sd6, 8'sd8, 8'sd10, 8'sd11,
        -8'sd13, -8'sd11, -8'sd10, -8'sd8, -8'sd6, -8'sd5, -8'sd3, -8'sd2,
        8'sd0, 8'sd1, 8'sd2, 8'sd4, 8'sd5, 8'sd6, 8'sd7, 8'sd9,
        -8'sd10, -8'sd9, -8'sd7, -8'sd6, -8'sd5, -8'sd4, -8'sd2, -8'sd1,
        8'sd0, 8'sd1, 8'sd2, 8'sd3, 8'sd4, 8'sd5, 8'sd6, 8'sd7,
        -8'sd8, -8'sd7, -8'sd6, -8'sd5, -8'sd4, -8'sd3, -8'sd2, -8'sd1,
        8'sd0, 8'sd1, 8'sd2, 8'sd3, 8'sd3, 8'sd4, 8'sd5, 8'sd6,
        -8'sd7, -8'sd6, -8'sd5, -8'sd4, -8'sd3, -8'sd3, -8'sd2, -8'sd1,
        8'sd0, 8'sd1, 8'sd1, 8'sd2, 8'sd3, 8'sd4, 8'sd4, 8'sd5,
        -8'sd6, -8'sd5, -8'sd4, -8'sd4, -8'sd3, -8'sd2, -8'sd1, -8'sd1
    };

endpackage

`default_nettype wire

FILE: sv/adpcm_nibble_predictive_decoder_top.sv
// top level of the nibble predictive adpcm decoder with output register and skid stage
//
// usage:
//   s_axis carries one input transfer per 4-bit code: tdata holds the block header
//   byte and the data byte. the decoder keeps a nibble position (0..47, wraps) and
//   picks the low nibble on even positions and the high nibble on odd ones, so the
//   same data byte is normally sent twice in a row
//   m_axis returns one transfer per input transfer: the wrapped 8-bit sample and
//   that sample times the volume register
//   volume is written through volume_wr_en / volume_wr_data while the stream is idle
//   the result of an input transfer is registered before it appears on m_axis
//   throughput: one code per cycle while s_axis_tready is high; the decode (table
//   lookup, predictor add, one 8x7 multiply) is a single pass between the input handshake and the result register
//   stall: a result not taken stays on m_axis; one more result parks in the skid
//   register, then s_axis_tready drops until the receiver takes data again
//   reset (aresetn low, synchronous): history and position clear, volume is 0,
//   both result registers empty
`timescale 1ns / 1ps
`default_nettype none

module adpcm_nibble_predictive_decoder_top
    import adpcm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // volume register write
    input  wire logic                 volume_wr_en,
    input  wire logic [VOLUME_W-1:0]  volume_wr_data,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] header_byte, [15:8] data_byte
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata    // [14:0] scaled_sample, [22:15] raw_sample, [23] zero
);

    // decoder state
    logic [VOLUME_W-1:0] volume_reg;
    sample_t             prev_reg;
    sample_t             older_reg;
    logic [POS_W-1:0]    pos_reg;

    // output register and skid stage
    logic                 out_valid_reg,  out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg,   out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [M_TDATA_W-1:0] skid_data_reg,  skid_data_next;

    logic [HDR_W-1:0]    hdr;
    logic [DAT_W-1:0]    dat;
    logic [3:0]          nib;
    logic [3:0]          row;
    pred_mode_t          mode;
    sample_t             step;
    logic signed [10:0]  sum_wide;
    sample_t             sample;
    sample_t             half_older;
    logic signed [15:0]  prod;
    logic [M_TDATA_W-1:0] result;
    logic                accept;
    logic                take;

    assign s_axis_tready = ~skid_valid_reg;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign take          = out_valid_reg & m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign hdr  = s_axis_tdata[HDR_W-1:0];
    assign dat  = s_axis_tdata[S_TDATA_W-1:HDR_W];
    assign mode = pred_mode_t'(hdr[5:4]);

    // odd positions use the high nibble
    assign nib = pos_reg[0] ? dat[7:4] : dat[3:0];

    // second half of the block: bit 6 lowers the row by one, bit 7 raises it by two
    always_comb begin
        row = hdr[3:0];
        if (pos_reg >= HALF_START) begin
            row = hdr[3:0] + (hdr[6] ? 4'hF : 4'h0) + (hdr[7] ? 4'h2 : 4'h0);
        end
    end

    assign step       = STEP_ROM[{row, nib}];
    assign half_older = older_reg >>> 1;

    always_comb begin
        unique case (mode)
            PRED_STEP: begin
                sum_wide = 11'(step);
            end
            PRED_PREV: begin
                sum_wide = 11'(step) + 11'(prev_reg);
            end
            PRED_SLOPE: begin
                sum_wide = 11'(step) + (11'(prev_reg) <<< 1) - 11'(older_reg);
            end
            PRED_HALF_OLD: begin
                sum_wide = 11'(step) + 11'(prev_reg) - 11'(half_older);
            end
            default: begin
                sum_wide = 11'(step);
            end
        endcase
    end

    // the sum wraps to 8 bits
    assign sample = sum_wide[SAMPLE_W-1:0];
    assign prod   = 16'(sample) * $signed({1'b0, volume_reg});
    assign result = {1'b0, sample, prod[SCALED_W-1:0]};

    // output register with one skid slot behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (accept) begin
                out_data_next = result;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (accept) begin
            if (out_valid_reg) begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end else begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg     <= '0;
            prev_reg       <= '0;
            older_reg      <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (volume_wr_en) begin
                volume_reg <= volume_wr_data;
            end
            if (accept) begin
                older_reg <= prev_reg;
                prev_reg  <= sample;
                pos_reg   <= (pos_reg >= BLOCK_LAST) ? '0 : pos_reg + POS_W'(1);
            end
        end
    end

    // payload only
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire
